// File: hw/rtl/rsf_pkg.sv
// Shared types and constants of the fenced ring suballocator.
// Holds the result status codes, the register map and the layout of one queued region.
// No dependencies.
`default_nettype none

package rsf_pkg;

   // Result status of one transaction.
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_QUEUE_FULL = 2'd2,
      STATUS_TOO_LARGE  = 2'd3
   } status_type;

   // Request action codes.
   localparam logic ACTION_ALLOCATE = 1'b0;
   localparam logic ACTION_RECLAIM  = 1'b1;

   // Register map of the configuration port.
   localparam int unsigned    CSR_ADDR_W         = 2;
   localparam logic [1:0]     CSR_ADDR_RING_SIZE = 2'd0;
   localparam logic [31:0]    RING_SIZE_RESET    = 32'd65536;

   // One queued region. The length is kept instead of the start offset,
   // since the start is only ever needed to recover the length.
   typedef struct packed {
      logic [63:0] expiry;
      logic [31:0] end_pos;
      logic [31:0] length;
   } entry_type;

endpackage

`default_nettype wire

// File: hw/rtl/rsf_region_mem.sv
// Region queue storage of the fenced ring suballocator.
// One write port and one read port with registered read data; uses rsf_pkg.
`default_nettype none

module rsf_region_mem #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire rsf_pkg::entry_type       wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output rsf_pkg::entry_type            rd_data
);

   rsf_pkg::entry_type mem_ff [DEPTH];
   rsf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ring_suballocator_with_fences_top.sv
// Top level of the fenced ring suballocator: control sequencer, ring pointers and CSR port.
// Uses rsf_pkg and instantiates rsf_region_mem for the region queue.
//
// Usage
//   The req channel carries one transaction per item: an allocate (size,
//   alignment, expiry date) or a reclaim (current date). The rsp channel
//   returns exactly one transaction per request, in order: status, granted
//   offset, number of regions freed and the used byte count afterwards.
//   Both channels are valid/ready. The CSR port holds ring_size at address 0
//   and must only be written while no request is in flight.
// Sequencing
//   An allocate is taken in the acceptance cycle, which computes the free
//   space and the alignment padding, and then ST_DECIDE decides the
//   placement and writes the region queue once the output register is free.
//   A reclaim pops the expired regions in ST_POP: the queue memory is read
//   once per popped entry, and each pop consumes its registered read data.
// Reset and stalls
//   Reset empties the queue, clears the pointers and the used count and
//   sets ring_size to 65536; the queue memory itself is not cleared, since
//   only entries that were written are ever read. A result waits in the
//   output register while the receiver stalls; the next request is still
//   accepted and processed up to the point where its own result is written.
`default_nettype none

module ring_suballocator_with_fences_top #(
   parameter int unsigned REGION_QUEUE_DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_action,
   input  wire logic [31:0]                     req_request_size,
   input  wire logic [4:0]                      req_alignment_log2,
   input  wire logic [63:0]                     req_date,
   // Response channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [31:0]                          rsp_region_offset,
   output logic [4:0]                           rsp_regions_freed,
   output logic [31:0]                          rsp_bytes_in_use,
   // Configuration port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rsf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned IDX_W = $clog2(REGION_QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(REGION_QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(REGION_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(REGION_QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_POP
   } state_type;

   // Control state.
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         ring_size_ff, ring_size_in;
   logic [31:0]         write_pos_ff, write_pos_in;
   logic [31:0]         begin_pos_ff, begin_pos_in;
   logic [31:0]         used_ff, used_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [4:0]          freed_ff, freed_in;

   // Request payload and precomputed placement terms.
   logic [31:0]         size_ff, size_in;
   logic [63:0]         date_ff, date_in;
   logic [31:0]         pad_ff, pad_in;
   logic [31:0]         space_ff, space_in;
   logic [31:0]         aligned_ff, aligned_in;
   logic                too_large_ff, too_large_in;
   logic                full_ff, full_in;
   logic                linear_ff, linear_in;
   logic                wrap_ok_ff, wrap_ok_in;

   // Response payload.
   rsf_pkg::status_type status_ff, status_in;
   logic [31:0]         offset_ff, offset_in;
   logic [4:0]          rsp_freed_ff, rsp_freed_in;
   logic [31:0]         bytes_ff, bytes_in;

   // Datapath wires.
   logic                accept;
   logic                out_free;
   logic [31:0]         tail_space;
   logic [31:0]         align_mask;
   logic [32:0]         need;
   logic                fit;
   logic                grant;
   logic [31:0]         grant_pos;
   logic [32:0]         used_sum;
   logic                pop;
   logic [IDX_W-1:0]    head_inc;
   logic [IDX_W-1:0]    tail_inc;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   rsf_pkg::entry_type  wr_entry;
   rsf_pkg::entry_type  rd_entry;
   logic                csr_write;
   logic [CNT_W-1:0]    occupancy;

   rsf_region_mem #(
      .DEPTH (REGION_QUEUE_DEPTH)
   ) u_region_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == rsf_pkg::CSR_ADDR_RING_SIZE) ? ring_size_ff : 32'd0;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);

   // Placement terms, taken from the request ports in the acceptance cycle.
   // With the write position beyond a shrunken ring the tail space is zero.
   assign tail_space = (ring_size_ff > write_pos_ff) ? (ring_size_ff - write_pos_ff) : 32'd0;
   assign align_mask = (32'd1 << req_alignment_log2) - 32'd1;

   // Decision terms, from registered values.
   assign need     = {1'b0, pad_ff} + {1'b0, size_ff};
   assign fit      = (need <= {1'b0, space_ff});
   assign used_sum = {1'b0, used_ff} + {1'b0, size_ff};

   // A queued region is released once its expiry date is not later than the
   // current date. The read data belongs to the current head entry.
   assign pop     = (state_ff == ST_POP) && (count_ff != '0) && (rd_entry.expiry <= date_ff);
   assign rd_addr = pop ? head_inc : head_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ring_size_in = ring_size_ff;
      write_pos_in = write_pos_ff;
      begin_pos_in = begin_pos_ff;
      used_in      = used_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      freed_in     = freed_ff;

      size_in      = size_ff;
      date_in      = date_ff;
      pad_in       = pad_ff;
      space_in     = space_ff;
      aligned_in   = aligned_ff;
      too_large_in = too_large_ff;
      full_in      = full_ff;
      linear_in    = linear_ff;
      wrap_ok_in   = wrap_ok_ff;

      status_in    = status_ff;
      offset_in    = offset_ff;
      rsp_freed_in = rsp_freed_ff;
      bytes_in     = bytes_ff;

      grant     = 1'b0;
      grant_pos = 32'd0;
      mem_we    = 1'b0;
      wr_entry  = '{expiry: date_ff, end_pos: 32'd0, length: size_ff};

      if (csr_write && (csr_paddr == rsf_pkg::CSR_ADDR_RING_SIZE)) begin
         ring_size_in = csr_pwdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               size_in      = req_request_size;
               date_in      = req_date;
               freed_in     = 5'd0;
               // The ring is in linear order when the free space runs from
               // the write position to the end, possibly wrapping to zero.
               linear_in    = (begin_pos_ff < write_pos_ff) ||
                              ((begin_pos_ff == write_pos_ff) && (used_ff == 32'd0));
               space_in     = linear_in ? tail_space : (begin_pos_ff - write_pos_ff);
               pad_in       = (32'd0 - write_pos_ff) & align_mask;
               aligned_in   = write_pos_ff + pad_in;
               too_large_in = (req_request_size >= ring_size_ff);
               full_in      = (count_ff == FULL_COUNT);
               wrap_ok_in   = (req_request_size <= begin_pos_ff);
               state_in     = (req_action == rsf_pkg::ACTION_RECLAIM) ? ST_POP : ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               priority if (too_large_ff) begin
                  status_in = rsf_pkg::STATUS_TOO_LARGE;
               end else if (full_ff) begin
                  status_in = rsf_pkg::STATUS_QUEUE_FULL;
               end else if (fit) begin
                  status_in = rsf_pkg::STATUS_OK;
                  grant     = 1'b1;
                  grant_pos = aligned_ff;
               end else if (linear_ff && wrap_ok_ff) begin
                  // The skipped tail is not counted as used.
                  status_in = rsf_pkg::STATUS_OK;
                  grant     = 1'b1;
                  grant_pos = 32'd0;
               end else begin
                  status_in = rsf_pkg::STATUS_NO_SPACE;
               end

               if (grant) begin
                  used_in          = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
                  write_pos_in     = grant_pos + size_ff;
                  mem_we           = 1'b1;
                  wr_entry.end_pos = grant_pos + size_ff;
                  tail_in          = tail_inc;
                  count_in         = count_ff + CNT_W'(1);
               end

               offset_in    = grant_pos;
               rsp_freed_in = 5'd0;
               bytes_in     = used_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_POP: begin
            if (pop) begin
               begin_pos_in = rd_entry.end_pos;
               used_in      = (used_ff >= rd_entry.length) ? (used_ff - rd_entry.length)
                                                           : 32'd0;
               head_in      = head_inc;
               count_in     = count_ff - CNT_W'(1);
               freed_in     = freed_ff + 5'd1;
            end else if (out_free) begin
               status_in    = rsf_pkg::STATUS_OK;
               offset_in    = 32'd0;
               rsp_freed_in = freed_ff;
               bytes_in     = used_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ring_size_ff <= rsf_pkg::RING_SIZE_RESET;
         write_pos_ff <= 32'd0;
         begin_pos_ff <= 32'd0;
         used_ff      <= 32'd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         freed_ff     <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_size_ff <= ring_size_in;
         write_pos_ff <= write_pos_in;
         begin_pos_ff <= begin_pos_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         freed_ff     <= freed_in;
      end
      size_ff      <= size_in;
      date_ff      <= date_in;
      pad_ff       <= pad_in;
      space_ff     <= space_in;
      aligned_ff   <= aligned_in;
      too_large_ff <= too_large_in;
      full_ff      <= full_in;
      linear_ff    <= linear_in;
      wrap_ok_ff   <= wrap_ok_in;
      status_ff    <= status_in;
      offset_ff    <= offset_in;
      rsp_freed_ff <= rsp_freed_in;
      bytes_ff     <= bytes_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_region_offset = offset_ff;
   assign rsp_regions_freed = rsp_freed_ff;
   assign rsp_bytes_in_use  = bytes_ff;

   // Distance from head to tail around the queue, for the pointer check below.
   assign occupancy = (tail_ff >= head_ff) ? (CNT_W'(tail_ff) - CNT_W'(head_ff))
                                           : (CNT_W'(tail_ff) + FULL_COUNT - CNT_W'(head_ff));

   // The queue never holds more regions than it has entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("region queue count exceeds its depth");

   // Head, tail and count stay consistent with each other.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_COUNT) ? (tail_ff == head_ff) : (occupancy == count_ff))
      else $error("region queue pointers disagree with the count");

   // A region is only written into a queue that has room for it.
   assert property (@(posedge clock) disable iff (reset) mem_we |-> (count_ff < FULL_COUNT))
      else $error("region written into a full queue");

   // Every pop releases exactly one region and moves the head.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> ((count_ff == $past(count_ff) - CNT_W'(1)) && (head_ff != $past(head_ff)
               || REGION_QUEUE_DEPTH == 1)))
      else $error("pop did not release one region");

   // An accepted request always leaves the idle state for its own processing.
   assert property (@(posedge clock) disable iff (reset) accept |=> (state_ff != ST_IDLE))
      else $error("accepted request was not processed");

endmodule

`default_nettype wire
